// ===== rtl/core/zbg_pkg.sv =====
// Shared constants, register indexes and types for the zoned bar graph level meter.
package zbg_pkg;

   localparam int SEGMENTS   = 12;
   localparam int ZONE_SIZE  = SEGMENTS / 3;
   localparam int LOWER_ZONE = 2 * ZONE_SIZE;

   localparam int READING_W   = 16;
   localparam int LIT_COUNT_W = 4;
   localparam int LIT_MASK_W  = 12;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   // internal widths
   localparam int CNT_W  = $clog2(SEGMENTS + 1);
   localparam int SPAN_W = READING_W + 1;
   localparam int NUM_W  = SPAN_W + $clog2(LOWER_ZONE + 1);
   localparam int STEP_W = $clog2(NUM_W + 1);

   localparam logic [CSR_IDX_W-1:0] REG_ZONE_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_BOUND   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LOWER_BREAK = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_UPPER_BREAK = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_BOUND  = 3'd4;

   localparam logic MODE_THREE_ZONE = 1'b0;
   localparam logic MODE_TWO_ZONE   = 1'b1;

   localparam logic signed [READING_W-1:0] LOW_BOUND_RST   = 16'sd0;
   localparam logic signed [READING_W-1:0] LOWER_BREAK_RST = 16'sd1024;
   localparam logic signed [READING_W-1:0] UPPER_BREAK_RST = 16'sd2048;
   localparam logic signed [READING_W-1:0] HIGH_BOUND_RST  = 16'sd4096;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIV,
      ST_FINISH
   } zbg_state_type;

endpackage

// ===== rtl/core/zbg_ifs.sv =====
// Valid/ready channel interfaces for reading, result and register write beats.
interface zbg_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [zbg_pkg::READING_W-1:0] reading;

   modport source (output valid, output reading, input ready);
   modport sink   (input valid, input reading, output ready);
endinterface

interface zbg_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [zbg_pkg::LIT_COUNT_W-1:0]  lit_count;
   logic [zbg_pkg::LIT_MASK_W-1:0]   lit_mask;
   logic                             applied;

   modport source (output valid, output lit_count, output lit_mask, output applied,
                   input ready);
   modport sink   (input valid, input lit_count, input lit_mask, input applied,
                   output ready);
endinterface

interface zbg_csr_if;
   logic                            valid;
   logic                            ready;
   logic [zbg_pkg::CSR_IDX_W-1:0]   index;
   logic [zbg_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/zbg_div.sv =====
// Restoring divider, one quotient bit per cycle.
module zbg_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [zbg_pkg::NUM_W-1:0]   numer,
   input  logic [zbg_pkg::SPAN_W-1:0]  denom,
   output logic                        done,
   output logic [zbg_pkg::NUM_W-1:0]   quot
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [zbg_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [zbg_pkg::SPAN_W-1:0]   rem_ff, rem_in;
   logic [zbg_pkg::SPAN_W-1:0]   den_ff, den_in;
   logic [zbg_pkg::NUM_W-1:0]    quo_ff, quo_in;
   logic [zbg_pkg::SPAN_W:0]     trial;
   logic [zbg_pkg::SPAN_W+1:0]   diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[zbg_pkg::NUM_W-1]};
      diff    = {1'b0, trial} - {2'b00, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = zbg_pkg::STEP_W'(zbg_pkg::NUM_W);
         rem_in  = '0;
         den_in  = denom;
         quo_in  = numer;
      end else if (busy_ff) begin
         if (diff[zbg_pkg::SPAN_W+1]) begin
            rem_in = trial[zbg_pkg::SPAN_W-1:0];
         end else begin
            rem_in = diff[zbg_pkg::SPAN_W-1:0];
         end
         quo_in  = {quo_ff[zbg_pkg::NUM_W-2:0], ~diff[zbg_pkg::SPAN_W+1]};
         step_in = step_ff - 1'b1;
         if (step_ff == zbg_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

// ===== rtl/core/zoned_bar_graph_level.sv =====
// Top level: piecewise-linear 12-segment bar graph level meter.
// Steps: the accepted reading is registered; setup finishes at once when no division
// is needed (bad breakpoints or reading at/outside a bound), else starts the divider and
// waits for its quotient; finish loads the result beat. Ready returns as it is loaded,
// so a reading is through before the next is taken; that may be while the beat waits.
// Reset (synchronous): registers to their defaults, bar dark, no result pending.
module zoned_bar_graph_level (
   input  logic      clock,
   input  logic      reset,
   zbg_req_if.sink   req_ch,
   zbg_rsp_if.source rsp_ch,
   zbg_csr_if.sink   csr_ch
);

   localparam int CW = zbg_pkg::CNT_W;

   // configuration
   logic                                  zone_mode_ff;
   logic signed [zbg_pkg::READING_W-1:0]  low_bound_ff, lower_break_ff;
   logic signed [zbg_pkg::READING_W-1:0]  upper_break_ff, high_bound_ff;

   zbg_pkg::zbg_state_type                state_ff, state_in;
   logic signed [zbg_pkg::READING_W-1:0]  reading_ff, reading_in;
   logic [CW-1:0]                         base_ff, base_in;
   logic [CW-1:0]                         result_ff, result_in;
   logic                                  applied_ff, applied_in;
   logic [CW-1:0]                         shown_ff, shown_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [zbg_pkg::LIT_COUNT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic [zbg_pkg::LIT_MASK_W-1:0]        rsp_mask_ff, rsp_mask_in;
   logic                                  rsp_applied_ff, rsp_applied_in;

   logic                                  cfg_ok;
   logic [CW-1:0]                         zone_base, zone_size;
   logic [zbg_pkg::SPAN_W-1:0]            zone_ofs, zone_span;
   logic [zbg_pkg::SPAN_W-1:0]            d_low, d_lower, d_upper;
   logic [zbg_pkg::SPAN_W-1:0]            s_lower, s_upper_lo, s_upper_hi, s_high_lo;
   logic [zbg_pkg::LIT_MASK_W-1:0]        mask;

   logic                                  div_start, div_done;
   logic [zbg_pkg::NUM_W-1:0]             div_numer, div_quot;
   logic [zbg_pkg::SPAN_W-1:0]            div_denom;

   zbg_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (div_denom),
      .done  (div_done),
      .quot  (div_quot)
   );

   // register writes, taken any cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         zone_mode_ff   <= zbg_pkg::MODE_THREE_ZONE;
         low_bound_ff   <= zbg_pkg::LOW_BOUND_RST;
         lower_break_ff <= zbg_pkg::LOWER_BREAK_RST;
         upper_break_ff <= zbg_pkg::UPPER_BREAK_RST;
         high_bound_ff  <= zbg_pkg::HIGH_BOUND_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            zbg_pkg::REG_ZONE_MODE:   zone_mode_ff   <= csr_ch.data[0];
            zbg_pkg::REG_LOW_BOUND:   low_bound_ff   <= csr_ch.data;
            zbg_pkg::REG_LOWER_BREAK: lower_break_ff <= csr_ch.data;
            zbg_pkg::REG_UPPER_BREAK: upper_break_ff <= csr_ch.data;
            zbg_pkg::REG_HIGH_BOUND:  high_bound_ff  <= csr_ch.data;
            default: ;
         endcase
      end
   end

   assign csr_ch.ready = 1'b1;

   // breakpoint check and zone selection
   always_comb begin
      if (zone_mode_ff == zbg_pkg::MODE_TWO_ZONE) begin
         cfg_ok = (low_bound_ff < lower_break_ff) && (lower_break_ff < high_bound_ff);
      end else begin
         cfg_ok = (low_bound_ff < lower_break_ff) && (lower_break_ff < upper_break_ff) &&
                  (upper_break_ff < high_bound_ff);
      end
      d_low      = {reading_ff[15], reading_ff} - {low_bound_ff[15], low_bound_ff};
      d_lower    = {reading_ff[15], reading_ff} - {lower_break_ff[15], lower_break_ff};
      d_upper    = {reading_ff[15], reading_ff} - {upper_break_ff[15], upper_break_ff};
      s_lower    = {lower_break_ff[15], lower_break_ff} - {low_bound_ff[15], low_bound_ff};
      s_upper_lo = {upper_break_ff[15], upper_break_ff} -
                   {lower_break_ff[15], lower_break_ff};
      s_upper_hi = {high_bound_ff[15], high_bound_ff} -
                   {upper_break_ff[15], upper_break_ff};
      s_high_lo  = {high_bound_ff[15], high_bound_ff} - {lower_break_ff[15], lower_break_ff};
      if (reading_ff < lower_break_ff) begin
         zone_base = '0;
         zone_ofs  = d_low;
         zone_span = s_lower;
         zone_size = (zone_mode_ff == zbg_pkg::MODE_TWO_ZONE) ? CW'(zbg_pkg::LOWER_ZONE)
                                                              : CW'(zbg_pkg::ZONE_SIZE);
      end else if (zone_mode_ff == zbg_pkg::MODE_TWO_ZONE) begin
         zone_base = CW'(zbg_pkg::LOWER_ZONE);
         zone_ofs  = d_lower;
         zone_span = s_high_lo;
         zone_size = CW'(zbg_pkg::ZONE_SIZE);
      end else if (reading_ff < upper_break_ff) begin
         zone_base = CW'(zbg_pkg::ZONE_SIZE);
         zone_ofs  = d_lower;
         zone_span = s_upper_lo;
         zone_size = CW'(zbg_pkg::ZONE_SIZE);
      end else begin
         zone_base = CW'(zbg_pkg::LOWER_ZONE);
         zone_ofs  = d_upper;
         zone_span = s_upper_hi;
         zone_size = CW'(zbg_pkg::ZONE_SIZE);
      end
   end

   always_comb begin
      for (int i = 0; i < zbg_pkg::LIT_MASK_W; i++) begin
         mask[i] = (int'(result_ff) > i);
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      reading_in     = reading_ff;
      base_in        = base_ff;
      result_in      = result_ff;
      applied_in     = applied_ff;
      shown_in       = shown_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_count_in   = rsp_count_ff;
      rsp_mask_in    = rsp_mask_ff;
      rsp_applied_in = rsp_applied_ff;
      div_start      = 1'b0;
      div_numer      = '0;
      div_denom      = '0;
      unique case (state_ff)
         zbg_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               reading_in = req_ch.reading;
               state_in   = zbg_pkg::ST_SETUP;
            end
         end
         zbg_pkg::ST_SETUP: begin
            applied_in = cfg_ok;
            if (!cfg_ok) begin
               result_in = shown_ff;
               state_in  = zbg_pkg::ST_FINISH;
            end else if (reading_ff <= low_bound_ff) begin
               result_in = '0;
               state_in  = zbg_pkg::ST_FINISH;
            end else if (reading_ff >= high_bound_ff) begin
               result_in = CW'(zbg_pkg::SEGMENTS);
               state_in  = zbg_pkg::ST_FINISH;
            end else begin
               base_in   = zone_base;
               div_start = 1'b1;
               div_numer = zbg_pkg::NUM_W'(zone_ofs) * zbg_pkg::NUM_W'(zone_size);
               div_denom = zone_span;
               state_in  = zbg_pkg::ST_DIV;
            end
         end
         zbg_pkg::ST_DIV: begin
            if (div_done) begin
               result_in = base_ff + div_quot[CW-1:0];
               state_in  = zbg_pkg::ST_FINISH;
            end
         end
         zbg_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_count_in   = zbg_pkg::LIT_COUNT_W'(result_ff);
               rsp_mask_in    = mask;
               rsp_applied_in = applied_ff;
               shown_in       = result_ff;
               state_in       = zbg_pkg::ST_IDLE;
            end
         end
         default: state_in = zbg_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= zbg_pkg::ST_IDLE;
         shown_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         shown_ff     <= shown_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      reading_ff     <= reading_in;
      base_ff        <= base_in;
      result_ff      <= result_in;
      applied_ff     <= applied_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_mask_ff    <= rsp_mask_in;
      rsp_applied_ff <= rsp_applied_in;
   end

   assign req_ch.ready     = (state_ff == zbg_pkg::ST_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.lit_count = rsp_count_ff;
   assign rsp_ch.lit_mask  = rsp_mask_ff;
   assign rsp_ch.applied   = rsp_applied_ff;

   // divider is only started from setup and never while a division runs
   assert property (@(posedge clock) disable iff (reset)
      div_start |=> (state_ff == zbg_pkg::ST_DIV))
      else $error("divider start without entering divide state");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == zbg_pkg::ST_DIV) && div_done |=> (state_ff == zbg_pkg::ST_FINISH))
      else $error("divider result dropped");

   // a beat marked not applied repeats the bar that is still shown
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_applied_ff |->
         rsp_count_ff == zbg_pkg::LIT_COUNT_W'(shown_ff))
      else $error("rejected beat does not match shown count");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == zbg_pkg::ST_FINISH) && !rsp_valid_ff |=> rsp_valid_ff &&
         (state_ff == zbg_pkg::ST_IDLE))
      else $error("finished result not moved to output register");

endmodule

// ===== bench/zbg_level_checker.sv =====
// Bar graph level checker: tracks register writes, predicts each result beat, compares.
module zbg_level_checker (
   input  logic clock,
   input  logic reset,
   zbg_req_if   req_ch,
   zbg_rsp_if   rsp_ch,
   zbg_csr_if   csr_ch,
   output int   mismatch_count,
   output int   results_owed
);
   timeunit 1ns;
   timeprecision 1ps;
   import zbg_pkg::*;

   typedef struct packed {
      logic [LIT_COUNT_W-1:0] lit_count;
      logic [LIT_MASK_W-1:0]  lit_mask;
      logic                   applied;
   } bar_view_type;

   logic                         zone_mode;
   logic signed [READING_W-1:0]  low_bound;
   logic signed [READING_W-1:0]  lower_break;
   logic signed [READING_W-1:0]  upper_break;
   logic signed [READING_W-1:0]  high_bound;
   logic [LIT_COUNT_W-1:0]       shown_count;
   bar_view_type                 shown_bar_q[$];

   function automatic int zone_fill(int base, int offset, int span, int size);
      return base + (offset * size) / span;
   endfunction

   function automatic int bar_level(int v);
      int lo, lb, ub, hi;
      lo = low_bound;
      lb = lower_break;
      ub = upper_break;
      hi = high_bound;
      if (v <= lo) return 0;
      if (v >= hi) return SEGMENTS;
      if (zone_mode == MODE_TWO_ZONE) begin
         if (v < lb) return zone_fill(0, v - lo, lb - lo, LOWER_ZONE);
         return zone_fill(LOWER_ZONE, v - lb, hi - lb, ZONE_SIZE);
      end
      if (v < lb) return zone_fill(0, v - lo, lb - lo, ZONE_SIZE);
      if (v < ub) return zone_fill(ZONE_SIZE, v - lb, ub - lb, ZONE_SIZE);
      return zone_fill(LOWER_ZONE, v - ub, hi - ub, ZONE_SIZE);
   endfunction

   function automatic logic breaks_ok();
      if (zone_mode == MODE_TWO_ZONE)
         return low_bound < lower_break && lower_break < high_bound;
      return low_bound < lower_break && lower_break < upper_break &&
             upper_break < high_bound;
   endfunction

   // updates the displayed count, so call once per accepted reading
   function automatic bar_view_type advance_bar(logic signed [READING_W-1:0] reading);
      bar_view_type view;
      int           m;
      view.applied = breaks_ok();
      if (view.applied) shown_count = LIT_COUNT_W'(bar_level(int'(reading)));
      m = (1 << shown_count) - 1;
      view.lit_count = shown_count;
      view.lit_mask  = m[LIT_MASK_W-1:0];
      return view;
   endfunction

   always @(posedge clock) begin
      bar_view_type want;
      if (reset) begin
         zone_mode      = MODE_THREE_ZONE;
         low_bound      = LOW_BOUND_RST;
         lower_break    = LOWER_BREAK_RST;
         upper_break    = UPPER_BREAK_RST;
         high_bound     = HIGH_BOUND_RST;
         shown_count    = '0;
         mismatch_count = 0;
         shown_bar_q.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               REG_ZONE_MODE:   zone_mode   = csr_ch.data[0];
               REG_LOW_BOUND:   low_bound   = csr_ch.data;
               REG_LOWER_BREAK: lower_break = csr_ch.data;
               REG_UPPER_BREAK: upper_break = csr_ch.data;
               REG_HIGH_BOUND:  high_bound  = csr_ch.data;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            shown_bar_q.push_back(advance_bar(req_ch.reading));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (shown_bar_q.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected beat: count=%0d mask=%03h applied=%0b",
                           rsp_ch.lit_count, rsp_ch.lit_mask, rsp_ch.applied);
               mismatch_count++;
            end else begin
               want = shown_bar_q.pop_front();
               if (want.lit_count !== rsp_ch.lit_count || want.lit_mask !== rsp_ch.lit_mask ||
                   want.applied !== rsp_ch.applied) begin
                  if (mismatch_count < 10)
                     $display("mismatch: exp %0d/%03h/%0b got %0d/%03h/%0b",
                              want.lit_count, want.lit_mask, want.applied,
                              rsp_ch.lit_count, rsp_ch.lit_mask, rsp_ch.applied);
                  mismatch_count++;
               end
            end
         end
      end
      results_owed = shown_bar_q.size();
   end

endmodule

// ===== bench/zoned_bar_graph_level_tb.sv =====
// Bar graph level testbench top: clock, reset, reading and register traffic, verdict.
module zoned_bar_graph_level_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import zbg_pkg::*;

   localparam int DIRECTED_ITEMS = 24;
   localparam int RANDOM_ITEMS   = 450;
   localparam int HOLD_AT_BEAT   = DIRECTED_ITEMS + 20;
   localparam int HOLD_CYCLES    = 400;
   localparam int CYCLE_LIMIT    = 300000;
   localparam logic [CSR_IDX_W-1:0] FIRST_SPARE_REG = REG_HIGH_BOUND + 3'd1;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   results_owed;
   int   items_sent;
   int   beats_taken;
   int   cycle_count;
   int   lo_v, lb_v, ub_v, hi_v;

   zbg_req_if req_ch ();
   zbg_rsp_if rsp_ch ();
   zbg_csr_if csr_ch ();

   zoned_bar_graph_level dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   zbg_level_checker bar_check (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_ch         (csr_ch),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // all tasks below start and end at a falling edge
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input int value);
      csr_ch.index = index;
      csr_ch.data  = CSR_DATA_W'(value);
      csr_ch.valid = 1'b1;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic apply_setup(input logic mode, input int lo, input int lb, input int ub,
                              input int hi);
      lo_v = lo;
      lb_v = lb;
      ub_v = ub;
      hi_v = hi;
      write_reg(REG_ZONE_MODE, int'(mode));
      write_reg(REG_LOW_BOUND, lo);
      write_reg(REG_LOWER_BREAK, lb);
      write_reg(REG_UPPER_BREAK, ub);
      write_reg(REG_HIGH_BOUND, hi);
   endtask

   task automatic send_reading(input logic signed [READING_W-1:0] value);
      int gap;
      gap = ((items_sent / 40) % 3 == 2) ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid   = 1'b1;
      req_ch.reading = value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid = 1'b0;
      while (results_owed != 0) @(negedge clock);
   endtask

   function automatic int rand16();
      return int'($signed(16'($urandom)));
   endfunction

   function automatic int pick_reading();
      int sel;
      int v;
      sel = $urandom_range(0, 9);
      if (sel < 2 || lo_v >= hi_v) return rand16();
      if (sel == 2) begin
         case ($urandom_range(0, 3))
            0:       v = lo_v;
            1:       v = lb_v;
            2:       v = ub_v;
            default: v = hi_v;
         endcase
         v = v + int'($urandom_range(0, 2)) - 1;
      end else begin
         v = lo_v - 2 + int'($urandom_range(0, hi_v - lo_v + 4));
      end
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
      return v;
   endfunction

   task automatic random_setup();
      int   kind;
      int   pts[$];
      logic mode;
      kind = $urandom_range(0, 9);
      mode = 1'($urandom_range(0, 1));
      if (kind == 0) begin
         pts = '{rand16(), rand16(), rand16(), rand16()};
      end else if (kind == 1) begin
         pts.push_back(-32768 + int'($urandom_range(0, 65520)));
         repeat (3) pts.push_back(pts[pts.size()-1] + 1 + int'($urandom_range(0, 2)));
      end else if (kind == 2) begin
         pts.push_back(-32768);
         pts.push_back(-32767 + int'($urandom_range(0, 65532)));
         pts.push_back(pts[1] + 1 + int'($urandom_range(0, 32765 - pts[1])));
         pts.push_back(32767);
      end else begin
         do begin
            pts = '{rand16(), rand16(), rand16(), rand16()};
            pts.sort();
         end while (pts[0] == pts[1] || pts[1] == pts[2] || pts[2] == pts[3]);
         if (kind == 3) begin
            case ($urandom_range(0, 3))
               0:       pts[1] = pts[0];
               1:       pts[2] = pts[1];
               2:       pts[3] = pts[2];
               default: pts[0] = pts[3];
            endcase
         end else if (kind == 4 && mode == MODE_TWO_ZONE) begin
            pts[2] = rand16();
         end
      end
      if ($urandom_range(0, 4) == 0)
         write_reg(FIRST_SPARE_REG + CSR_IDX_W'($urandom_range(0, 2)), rand16());
      apply_setup(mode, pts[0], pts[1], pts[2], pts[3]);
   endtask

   initial begin
      int n;
      int reset_vals[$];
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.reading = '0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = '0;
      csr_ch.data    = '0;
      items_sent     = 0;
      lo_v = int'(LOW_BOUND_RST);
      lb_v = int'(LOWER_BREAK_RST);
      ub_v = int'(UPPER_BREAK_RST);
      hi_v = int'(HIGH_BOUND_RST);
      reset_vals = '{-32768, 0, 1, 1023, 1024, 2047, 2048, 4095, 4096, 32767, 3000};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset setup: three zones over 0..4096, every breakpoint and both extremes
      foreach (reset_vals[i])
         send_reading(16'(reset_vals[i]));
      wait_drained();
      // two zones; upper break unused and out of order
      apply_setup(MODE_TWO_ZONE, 0, 1024, -5, 4096);
      send_reading(16'sd100);
      send_reading(16'sd1023);
      send_reading(16'sd1024);
      send_reading(16'sd4095);
      send_reading(16'sd32767);
      wait_drained();
      // same breakpoints are invalid in three-zone mode: bar holds
      write_reg(REG_ZONE_MODE, int'(MODE_THREE_ZONE));
      send_reading(16'sd500);
      send_reading(-16'sd32768);
      wait_drained();
      // full-range bounds, writes to unused indexes ignored
      apply_setup(MODE_THREE_ZONE, -32768, -1, 0, 32767);
      write_reg(FIRST_SPARE_REG, 16'hFFFF);
      write_reg(FIRST_SPARE_REG + CSR_IDX_W'(2), 16'h8001);
      send_reading(-16'sd32768);
      send_reading(-16'sd32767);
      send_reading(-16'sd1);
      send_reading(16'sd0);
      send_reading(16'sd32766);
      send_reading(16'sd32767);

      n = 60;
      while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         wait_drained();
         random_setup();
         repeat (n) send_reading(16'(pick_reading()));
         n = $urandom_range(8, 40);
      end

      wait_drained();
      repeat (30) @(negedge clock);
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // result side; one long hold-off while readings keep coming
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      beats_taken  = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = ((beats_taken / 32) % 3 == 2) ? 0 : $urandom_range(0, 8);
         if (beats_taken == HOLD_AT_BEAT) gap = HOLD_CYCLES;
         if (gap > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         beats_taken++;
         @(negedge clock);
      end
   end

endmodule
